// ===== design/wwcb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the class weight table of the write coalescing buffer.
package wwcb_pkg;

   localparam int BUFFER_DEPTH = 32;
   localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int ITEM_W       = 16;
   localparam int MODEM_W      = 3;
   localparam int KEY_W        = ITEM_W + MODEM_W;
   localparam int CLASS_W      = 3;
   localparam int WEIGHT_W     = 8;
   localparam int CLIM_W       = 6;
   localparam int CMP_W        = (CNT_W > CLIM_W) ? CNT_W : CLIM_W;
   localparam int SERIAL_W     = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [WEIGHT_W-1:0] WEIGHT_LIMIT_RESET = 8'd20;
   localparam logic [CLIM_W-1:0]   COUNT_LIMIT_RESET  = 6'd32;

   // Register index, taken from paddr bit 2.
   localparam logic REG_WEIGHT_LIMIT = 1'b0;
   localparam logic REG_COUNT_LIMIT  = 1'b1;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FLUSH_RD,
      ST_FLUSH_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      logic [KEY_W-1:0]     wr_data;
      logic                 rd_en;
      logic [IDX_W-1:0]     rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0]  weight_limit;
      logic [CLIM_W-1:0]    count_limit;
   } limits_type;

   function automatic logic [WEIGHT_W-1:0] class_weight(input logic [CLASS_W-1:0] wclass);
      logic [WEIGHT_W-1:0] w;
      unique case (wclass)
         3'd0:    w = 8'd20;
         3'd1:    w = 8'd1;
         3'd2:    w = 8'd1;
         3'd3:    w = 8'd1;
         3'd4:    w = 8'd1;
         3'd5:    w = 8'd1;
         default: w = 8'd0;
      endcase
      return w;
   endfunction

endpackage

// ===== design/weighted_write_coalescing_buffer_unit.sv =====
`timescale 1ns / 1ps
// An add reads the stored entries one at a time through the single read port, stopping at
// a match, then passes through the update state; an add to an empty table goes straight to it.
// A flush reads the entries out one entry per cycle while rsp_ready is high; a forced flush
// of an empty table returns to idle without a readout.
// Reset (synchronous): count, weight and serial cleared, limits set to 20 and 32;
// table contents are not cleared and are only read below the entry count.
module weighted_write_coalescing_buffer_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [wwcb_pkg::ITEM_W-1:0]        req_item_id,
   input  logic [wwcb_pkg::MODEM_W-1:0]       req_modem_index,
   input  logic [wwcb_pkg::CLASS_W-1:0]       req_weight_class,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [wwcb_pkg::ITEM_W-1:0]        rsp_out_item_id,
   output logic [wwcb_pkg::MODEM_W-1:0]       rsp_out_modem_index,
   output logic [wwcb_pkg::SERIAL_W-1:0]      rsp_batch_serial,
   output logic                               rsp_last,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wwcb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wwcb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wwcb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import wwcb_pkg::*;

   limits_type        limits;
   ram_req_type       ram_req;
   logic [KEY_W-1:0]  ram_rdata;

   wwcb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   wwcb_entry_ram u_entry_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   wwcb_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .limits              (limits),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_item_id         (req_item_id),
      .req_modem_index     (req_modem_index),
      .req_weight_class    (req_weight_class),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_item_id     (rsp_out_item_id),
      .rsp_out_modem_index (rsp_out_modem_index),
      .rsp_batch_serial    (rsp_batch_serial),
      .rsp_last            (rsp_last),
      .ram_req             (ram_req),
      .ram_rdata           (ram_rdata)
   );

endmodule

// ===== design/wwcb_entry_ram.sv =====
`timescale 1ns / 1ps
// Entry table: one write port and one registered read port.
module wwcb_entry_ram (
   input  logic                           clock,
   input  wwcb_pkg::ram_req_type          ram_req,
   output logic [wwcb_pkg::KEY_W-1:0]     ram_rdata
);
   import wwcb_pkg::*;

   logic [KEY_W-1:0] mem [BUFFER_DEPTH];
   logic [KEY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Hold the last read word until the next read.
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rdata_ff <= mem[ram_req.rd_addr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

// ===== design/wwcb_csr.sv =====
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
module wwcb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wwcb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wwcb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wwcb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output wwcb_pkg::limits_type                limits
);
   import wwcb_pkg::*;

   logic [WEIGHT_W-1:0] weight_limit_ff, weight_limit_in;
   logic [CLIM_W-1:0]   count_limit_ff, count_limit_in;
   logic                wr_strobe;
   logic                reg_sel;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      weight_limit_in = weight_limit_ff;
      count_limit_in  = count_limit_ff;
      if (wr_strobe) begin
         unique case (reg_sel)
            REG_WEIGHT_LIMIT: weight_limit_in = csr_pwdata[WEIGHT_W-1:0];
            REG_COUNT_LIMIT:  count_limit_in  = csr_pwdata[CLIM_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_limit_ff <= WEIGHT_LIMIT_RESET;
         count_limit_ff  <= COUNT_LIMIT_RESET;
      end else begin
         weight_limit_ff <= weight_limit_in;
         count_limit_ff  <= count_limit_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_WEIGHT_LIMIT: csr_prdata = {{(CSR_DATA_W-WEIGHT_W){1'b0}}, weight_limit_ff};
         REG_COUNT_LIMIT:  csr_prdata = {{(CSR_DATA_W-CLIM_W){1'b0}}, count_limit_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign limits.weight_limit = weight_limit_ff;
   assign limits.count_limit  = count_limit_ff;

endmodule

// ===== design/wwcb_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: duplicate scan, append, weight update and flush readout.
module wwcb_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  wwcb_pkg::limits_type               limits,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [wwcb_pkg::ITEM_W-1:0]        req_item_id,
   input  logic [wwcb_pkg::MODEM_W-1:0]       req_modem_index,
   input  logic [wwcb_pkg::CLASS_W-1:0]       req_weight_class,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [wwcb_pkg::ITEM_W-1:0]        rsp_out_item_id,
   output logic [wwcb_pkg::MODEM_W-1:0]       rsp_out_modem_index,
   output logic [wwcb_pkg::SERIAL_W-1:0]      rsp_batch_serial,
   output logic                               rsp_last,
   output wwcb_pkg::ram_req_type              ram_req,
   input  logic [wwcb_pkg::KEY_W-1:0]         ram_rdata
);
   import wwcb_pkg::*;

   ctrl_state_type       state_ff, state_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [CLASS_W-1:0]   wclass_ff, wclass_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic [SERIAL_W-1:0]  serial_ff, serial_in;
   logic [IDX_W-1:0]     emit_idx_ff, emit_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ITEM_W-1:0]    rsp_item_ff, rsp_item_in;
   logic [MODEM_W-1:0]   rsp_modem_ff, rsp_modem_in;
   logic [SERIAL_W-1:0]  rsp_serial_ff, rsp_serial_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_fire;
   logic                 key_match;
   logic                 scan_done;
   logic                 emit_done;
   logic                 append;
   logic [CNT_W-1:0]     new_count;
   logic [WEIGHT_W:0]    weight_sum;
   logic [WEIGHT_W-1:0]  new_weight;
   logic                 flush_hit;
   logic                 out_free;
   logic                 out_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign key_match = (ram_rdata == key_ff);
   assign scan_done = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);
   assign emit_done = ((CNT_W'(emit_idx_ff) + CNT_W'(1)) == count_ff);
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   assign append     = ~found_ff & (count_ff < CNT_W'(BUFFER_DEPTH));
   assign new_count  = count_ff + CNT_W'(append);
   assign weight_sum = {1'b0, weight_ff} + {1'b0, class_weight(wclass_ff)};
   assign new_weight = weight_sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : weight_sum[WEIGHT_W-1:0];
   assign flush_hit  = (new_weight >= limits.weight_limit) ||
                       (CMP_W'(new_count) >= CMP_W'(limits.count_limit));

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      wclass_in   = wclass_ff;
      scan_idx_in = scan_idx_ff;
      found_in    = found_ff;
      count_in    = count_ff;
      weight_in   = weight_ff;
      serial_in   = serial_ff;
      emit_idx_in = emit_idx_ff;
      out_load    = 1'b0;
      ram_req     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in    = {req_item_id, req_modem_index};
               wclass_in = req_weight_class;
               found_in  = 1'b0;
               if (req_mode == MODE_FLUSH) begin
                  serial_in   = serial_ff + SERIAL_W'(1);
                  weight_in   = '0;
                  emit_idx_in = '0;
                  if (count_ff != '0) begin
                     state_in = ST_FLUSH_RD;
                  end
               end else if (count_ff == '0) begin
                  state_in = ST_UPDATE;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = '0;
                  scan_idx_in     = '0;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            priority if (key_match) begin
               found_in = 1'b1;
               state_in = ST_UPDATE;
            end else if (scan_done) begin
               state_in = ST_UPDATE;
            end else begin
               scan_idx_in     = scan_idx_ff + IDX_W'(1);
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_UPDATE: begin
            ram_req.wr_en   = append;
            ram_req.wr_addr = count_ff[IDX_W-1:0];
            ram_req.wr_data = key_ff;
            count_in        = new_count;
            if (flush_hit) begin
               serial_in   = serial_ff + SERIAL_W'(1);
               weight_in   = '0;
               emit_idx_in = '0;
               state_in    = (new_count != '0) ? ST_FLUSH_RD : ST_IDLE;
            end else begin
               weight_in = new_weight;
               state_in  = ST_IDLE;
            end
         end
         ST_FLUSH_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = emit_idx_ff;
            state_in        = ST_FLUSH_OUT;
         end
         ST_FLUSH_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (emit_done) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  // Fetch the next entry while this one moves to the output.
                  emit_idx_in     = emit_idx_ff + IDX_W'(1);
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = emit_idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_item_in   = rsp_item_ff;
      rsp_modem_in  = rsp_modem_ff;
      rsp_serial_in = rsp_serial_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_item_in   = ram_rdata[KEY_W-1:MODEM_W];
         rsp_modem_in  = ram_rdata[MODEM_W-1:0];
         rsp_serial_in = serial_ff;
         rsp_last_in   = emit_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         weight_ff    <= '0;
         serial_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         weight_ff    <= weight_in;
         serial_ff    <= serial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      wclass_ff     <= wclass_in;
      scan_idx_ff   <= scan_idx_in;
      found_ff      <= found_in;
      emit_idx_ff   <= emit_idx_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_modem_ff  <= rsp_modem_in;
      rsp_serial_ff <= rsp_serial_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_item_id     = rsp_item_ff;
   assign rsp_out_modem_index = rsp_modem_ff;
   assign rsp_batch_serial    = rsp_serial_ff;
   assign rsp_last            = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUFFER_DEPTH))
      else $error("entry count above buffer depth");

   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> (count_ff < CNT_W'(BUFFER_DEPTH)) && (state_ff == ST_UPDATE))
      else $error("table write without room");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && emit_done) |=> (count_ff == '0) && (state_ff == ST_IDLE))
      else $error("table not cleared after final entry");

   a_serial_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && (state_ff != ST_UPDATE) |=> $stable(serial_ff))
      else $error("serial changed during scan or readout");

   a_no_read_write_clash: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> !ram_req.rd_en)
      else $error("table read and write in the same cycle");
`endif

endmodule

// ===== sim/tb_weighted_write_coalescing_buffer_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the weighted write coalescing buffer unit.
module tb_weighted_write_coalescing_buffer_unit;
   import wwcb_pkg::*;

   localparam int RUN_LIMIT    = 200000;
   localparam int DRAIN_CYCLES = BUFFER_DEPTH + 8;
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic                mode;
      logic [ITEM_W-1:0]   item_id;
      logic [MODEM_W-1:0]  modem_index;
      logic [CLASS_W-1:0]  weight_class;
   } write_req_type;

   typedef struct packed {
      logic [ITEM_W-1:0]   item_id;
      logic [MODEM_W-1:0]  modem_index;
      logic [SERIAL_W-1:0] batch_serial;
      logic                last;
   } flushed_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_mode         = MODE_ADD;
   logic [ITEM_W-1:0]     req_item_id      = '0;
   logic [MODEM_W-1:0]    req_modem_index  = '0;
   logic [CLASS_W-1:0]    req_weight_class = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [ITEM_W-1:0]     rsp_out_item_id;
   logic [MODEM_W-1:0]    rsp_out_modem_index;
   logic [SERIAL_W-1:0]   rsp_batch_serial;
   logic                  rsp_last;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   weighted_write_coalescing_buffer_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the buffer
   logic [KEY_W-1:0]    shadow_table [BUFFER_DEPTH];
   int unsigned         shadow_count   = 0;
   int unsigned         shadow_weight  = 0;
   logic [SERIAL_W-1:0] shadow_serial  = '0;
   int unsigned         weight_threshold = WEIGHT_LIMIT_RESET;
   int unsigned         count_threshold  = COUNT_LIMIT_RESET;
   logic [7:0]          class_gain [8] = '{8'd20, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0};

   flushed_entry_type   flush_entries_due [$];
   write_req_type       request_queue [$];
   logic [KEY_W-1:0]    recent_keys [$];

   int unsigned issued = 0;
   int unsigned taken = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic release_batch();
      flushed_entry_type e;
      shadow_serial = shadow_serial + 1'b1;
      for (int k = 0; k < shadow_count; k++) begin
         e.item_id      = shadow_table[k][KEY_W-1:MODEM_W];
         e.modem_index  = shadow_table[k][MODEM_W-1:0];
         e.batch_serial = shadow_serial;
         e.last         = (k + 1 == shadow_count);
         flush_entries_due.push_back(e);
      end
      shadow_count  = 0;
      shadow_weight = 0;
   endtask

   task automatic absorb_request(input write_req_type r);
      logic [KEY_W-1:0] key;
      logic             hit;
      key = {r.item_id, r.modem_index};
      hit = 1'b0;
      if (r.mode == MODE_FLUSH) begin
         release_batch();
      end else begin
         for (int i = 0; i < shadow_count; i++)
            if (shadow_table[i] == key) hit = 1'b1;
         // drop new pairs once the table is full
         if (!hit && shadow_count < BUFFER_DEPTH) begin
            shadow_table[shadow_count] = key;
            shadow_count++;
         end
         shadow_weight = shadow_weight + class_gain[r.weight_class];
         if (shadow_weight > 255) shadow_weight = 255;
         if (shadow_weight >= weight_threshold || shadow_count >= count_threshold)
            release_batch();
      end
   endtask

   // request driver: bursts of random length with random gaps
   write_req_type offered;
   int unsigned   burst_left = 0;
   int unsigned   gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_request(offered);
            taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               offered = request_queue.pop_front();
               req_mode         <= offered.mode;
               req_item_id      <= offered.item_id;
               req_modem_index  <= offered.modem_index;
               req_weight_class <= offered.weight_class;
               req_valid        <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: own stall pattern, plus long hold-offs on request
   logic [15:0] stall_pattern = 16'hFFFF;
   int unsigned pattern_left = 0;
   int unsigned hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_left = 64;
               case ($urandom_range(0, 3))
                  0: stall_pattern = 16'hFFFF;
                  1: stall_pattern = 16'($urandom);
                  default: stall_pattern = 16'($urandom | $urandom);
               endcase
            end
            pattern_left--;
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            rsp_ready <= stall_pattern[0];
         end
      end
   end

   // result checker
   always @(posedge clock) begin : result_check
      flushed_entry_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (flush_entries_due.size() == 0) begin
            flag_mismatch($sformatf("result with nothing pending: item %h modem %0d serial %0d",
                                    rsp_out_item_id, rsp_out_modem_index, rsp_batch_serial));
         end else begin
            due = flush_entries_due.pop_front();
            if (rsp_out_item_id !== due.item_id)
               flag_mismatch($sformatf("item_id got %h want %h", rsp_out_item_id, due.item_id));
            if (rsp_out_modem_index !== due.modem_index)
               flag_mismatch($sformatf("modem_index got %0d want %0d",
                                       rsp_out_modem_index, due.modem_index));
            if (rsp_batch_serial !== due.batch_serial)
               flag_mismatch($sformatf("batch_serial got %0d want %0d",
                                       rsp_batch_serial, due.batch_serial));
            if (rsp_last !== due.last)
               flag_mismatch($sformatf("last got %b want %b", rsp_last, due.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_add(input logic [ITEM_W-1:0] item, input logic [MODEM_W-1:0] modem,
                           input logic [CLASS_W-1:0] wclass);
      write_req_type r;
      r.mode         = MODE_ADD;
      r.item_id      = item;
      r.modem_index  = modem;
      r.weight_class = wclass;
      request_queue.push_back(r);
      issued++;
      recent_keys.push_back({item, modem});
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
   endtask

   // forced flush with junk in the ignored fields
   task automatic push_flush();
      write_req_type r;
      r.mode         = MODE_FLUSH;
      r.item_id      = ITEM_W'($urandom);
      r.modem_index  = MODEM_W'($urandom);
      r.weight_class = CLASS_W'($urandom);
      request_queue.push_back(r);
      issued++;
   endtask

   task automatic push_random(input int unsigned n);
      logic [KEY_W-1:0]   key;
      logic [CLASS_W-1:0] wclass;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            push_flush();
         end else begin
            if (recent_keys.size() > 0 && $urandom_range(0, 9) < 3)
               key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else
               key = KEY_W'($urandom);
            case ($urandom_range(0, 9))
               0:       wclass = 3'd0;
               1:       wclass = 3'd6;
               2:       wclass = 3'd7;
               default: wclass = 3'($urandom_range(1, 5));
            endcase
            push_add(key[KEY_W-1:MODEM_W], key[MODEM_W-1:0], wclass);
         end
      end
   endtask

   // hold until every transaction is taken and every result has come
   task automatic wait_idle();
      while (taken != issued || flush_entries_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == REG_WEIGHT_LIMIT) weight_threshold = value & 8'hFF;
      else count_threshold = value & 6'h3F;
   endtask

   task automatic set_limits(input int unsigned wlim, input int unsigned clim);
      csr_write(REG_WEIGHT_LIMIT, wlim);
      csr_write(REG_COUNT_LIMIT, clim);
   endtask

   initial begin
      logic [9:0] hi_bits;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset limits: field extremes, duplicates, weightless classes, forced flushes
      push_add(16'h0000, 3'd0, 3'd1);
      push_add(16'hFFFF, 3'd7, 3'd1);
      push_add(16'hFFFF, 3'd7, 3'd2);
      push_add(16'h0000, 3'd7, 3'd7);
      push_add(16'hFFFF, 3'd0, 3'd6);
      push_flush();
      push_flush();
      push_add(16'hA5A5, 3'd5, 3'd0);
      push_add(16'h5A5A, 3'd2, 3'd1);
      push_add(16'h1234, 3'd3, 3'd2);
      push_add(16'h8001, 3'd4, 3'd3);
      push_add(16'h7FFE, 3'd1, 3'd4);
      push_add(16'h0F0F, 3'd6, 3'd5);
      push_add(16'h0F0F, 3'd6, 3'd0);
      push_add(16'hC3C3, 3'd1, 3'd3);
      push_flush();
      wait_idle();

      // count limit above depth: fill the table, overflow it, then saturate the weight
      set_limits(255, 63);
      for (int i = 0; i < BUFFER_DEPTH + 2; i++) begin
         hi_bits = 10'($urandom);
         push_add({hi_bits, 6'(i)}, 3'($urandom_range(0, 7)), 3'(6 + (i % 2)));
      end
      push_add(recent_keys[0][KEY_W-1:MODEM_W], recent_keys[0][MODEM_W-1:0], 3'd7);
      for (int i = 0; i < 13; i++) push_add(ITEM_W'($urandom), MODEM_W'($urandom), 3'd0);
      wait_idle();

      // zero limits: every add flushes
      set_limits(0, 32);
      push_random(6);
      wait_idle();
      set_limits(255, 0);
      push_random(6);
      wait_idle();

      set_limits(255, 32);
      push_random(15);
      wait_idle();

      set_limits(1, 32);
      push_random(10);
      wait_idle();

      // long receiver hold-off while the sender keeps offering
      set_limits(20, 4);
      hold_asked++;
      push_random(25);
      wait_idle();

      set_limits(255, 1);
      push_random(15);
      wait_idle();

      set_limits($urandom_range(2, 60), $urandom_range(2, 10));
      push_random(15);
      wait_idle();

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
